### src/text_case_converter_core_macros.svh
// ----------------------------------------------------------------------------
// Text case converter assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_CASE_CONVERTER_CORE_MACROS_SVH
`define TEXT_CASE_CONVERTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tcc_pkg.sv
// ----------------------------------------------------------------------------
// Text case converter package
// Mode codes, character constants and the per-byte conversion function.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned ModeW = 3;

  // Case mode codes; the codes above sentence case pass bytes through.
  typedef enum logic [ModeW-1:0] {
    MODE_UPPER    = 3'd0,
    MODE_LOWER    = 3'd1,
    MODE_TOGGLE   = 3'd2,
    MODE_WORD     = 3'd3,
    MODE_SENTENCE = 3'd4
  } mode_e;

  localparam logic [ModeW-1:0] ModeReset = MODE_UPPER;

  // Character constants.
  localparam logic [ByteW-1:0] ChUpA      = 8'h41;
  localparam logic [ByteW-1:0] ChUpZ      = 8'h5A;
  localparam logic [ByteW-1:0] ChLoA      = 8'h61;
  localparam logic [ByteW-1:0] ChLoZ      = 8'h7A;
  localparam logic [ByteW-1:0] ChDig0     = 8'h30;
  localparam logic [ByteW-1:0] ChDig9     = 8'h39;
  localparam logic [ByteW-1:0] ChUpI      = 8'h49;
  localparam logic [ByteW-1:0] ChDot      = 8'h2E;
  localparam logic [ByteW-1:0] ChBang     = 8'h21;
  localparam logic [ByteW-1:0] ChQuest    = 8'h3F;
  localparam logic [ByteW-1:0] ChUnder    = 8'h5F;
  localparam logic [ByteW-1:0] ChDash     = 8'h2D;
  localparam logic [ByteW-1:0] ChApos     = 8'h27;
  localparam logic [ByteW-1:0] Lat1UpLo   = 8'hC0;
  localparam logic [ByteW-1:0] Lat1UpHi   = 8'hDF;
  localparam logic [ByteW-1:0] Lat1LoLo   = 8'hE0;
  localparam logic [ByteW-1:0] CaseOffset = 8'd32;

  // Result of converting one byte, with the updated context flags.
  typedef struct packed {
    logic [ByteW-1:0] ch;
    logic             prev_sep;
    logic             in_sent;
  } conv_t;

  function automatic logic is_up(logic [ByteW-1:0] c);
    return (c >= ChUpA && c <= ChUpZ) || (c >= Lat1UpLo && c <= Lat1UpHi);
  endfunction

  function automatic logic is_low(logic [ByteW-1:0] c);
    return (c >= ChLoA && c <= ChLoZ) || (c >= Lat1LoLo);
  endfunction

  function automatic logic [ByteW-1:0] to_up(logic [ByteW-1:0] c);
    return is_low(c) ? c - CaseOffset : c;
  endfunction

  function automatic logic [ByteW-1:0] to_low(logic [ByteW-1:0] c);
    return is_up(c) ? c + CaseOffset : c;
  endfunction

  // A separator is anything but an ASCII letter, digit, or . _ - '.
  function automatic logic is_sep(logic [ByteW-1:0] c);
    logic alnum;
    alnum = (c >= ChUpA && c <= ChUpZ) || (c >= ChLoA && c <= ChLoZ) ||
            (c >= ChDig0 && c <= ChDig9);
    return !alnum && c != ChDot && c != ChUnder && c != ChDash && c != ChApos;
  endfunction

  // Convert one byte given the mode, the separator flag of the following
  // byte and the current context.
  function automatic conv_t convert(logic [ByteW-1:0] c, logic next_sep,
                                    logic [ModeW-1:0] mode, logic prev_sep,
                                    logic in_sent);
    conv_t r;
    r.ch      = c;
    r.in_sent = in_sent;
    unique case (mode)
      MODE_UPPER: r.ch = to_up(c);
      MODE_LOWER: r.ch = to_low(c);
      MODE_TOGGLE: r.ch = is_low(c) ? to_up(c) : to_low(c);
      MODE_WORD: begin
        if (is_up(c) && !prev_sep) begin
          r.ch = to_low(c);
        end else if (is_low(c) && prev_sep) begin
          r.ch = to_up(c);
        end
      end
      MODE_SENTENCE: begin
        if (in_sent) begin
          // An isolated I stays upper case.
          if (to_up(c) == ChUpI && prev_sep && next_sep) begin
            r.ch = ChUpI;
          end else begin
            r.ch = to_low(c);
          end
          if ((r.ch == ChDot || r.ch == ChBang || r.ch == ChQuest) && next_sep) begin
            r.in_sent = 1'b0;
          end
        end else if (!is_sep(c)) begin
          r.ch      = to_up(c);
          r.in_sent = 1'b1;
        end
      end
      default: r.ch = c;
    endcase
    r.prev_sep = is_sep(r.ch);
    return r;
  endfunction

endpackage

### src/text_case_converter_core.sv
// ----------------------------------------------------------------------------
// Text case converter core
// Streaming Latin-1 case converter with one byte of lookahead.
// ----------------------------------------------------------------------------
// Each byte is held until the next byte arrives, so that the converter knows
// whether a separator follows; it is then converted in one pass of logic into
// the output register. One item is accepted per clock while text flows and the
// output is not stalled. The final byte of a text (tlast) is released in the
// cycle after it is accepted, or later while a stalled output item still waits,
// and until then no new item is taken. After the final byte the word and
// sentence context returns to its reset value. The case mode is written through
// cfg_we_i / cfg_wdata_i: 0 upper, 1 lower, 2 toggle, 3 word case, 4 sentence
// case, other codes pass bytes through. The user must write it only while the
// block is idle; the block itself does not enforce this.
module text_case_converter_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration: case mode.
  input  logic                         cfg_we_i,
  input  logic [tcc_pkg::ModeW-1:0]    cfg_wdata_i,
  // Input stream.
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [tcc_pkg::ByteW-1:0]    s_axis_tdata_i,   // [7:0] text_byte
  input  logic                         s_axis_tlast_i,   // end_of_text
  // Output stream.
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [tcc_pkg::ByteW-1:0]    m_axis_tdata_o,   // [7:0] out_byte
  output logic                         m_axis_tlast_o    // out_last
);

  logic [tcc_pkg::ModeW-1:0] mode_q;
  logic [tcc_pkg::ByteW-1:0] held_q, held_d;
  logic                      held_valid_q, held_valid_d;
  logic                      held_last_q, held_last_d;
  logic                      prev_sep_q, prev_sep_d;
  logic                      in_sent_q, in_sent_d;
  logic                      out_valid_q, out_valid_d;
  logic [tcc_pkg::ByteW-1:0] out_byte_q, out_byte_d;
  logic                      out_last_q, out_last_d;

  logic          out_free;
  logic          in_accept;
  logic          release_held;
  logic          next_sep;
  tcc_pkg::conv_t conv;

  // Handshake: a held final byte blocks input until it is released.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !held_valid_q || (!held_last_q && out_free);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign release_held    = held_valid_q && (held_last_q ? out_free : in_accept);

  // Convert the held byte; the end of the text counts as a separator.
  assign next_sep = held_last_q ? 1'b1 : tcc_pkg::is_sep(s_axis_tdata_i);
  assign conv     = tcc_pkg::convert(held_q, next_sep, mode_q, prev_sep_q, in_sent_q);

  // Next-state logic for the hold stage, context and output register.
  always_comb begin
    held_d       = held_q;
    held_valid_d = held_valid_q;
    held_last_d  = held_last_q;
    prev_sep_d   = prev_sep_q;
    in_sent_d    = in_sent_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;

    if (release_held) begin
      out_valid_d = 1'b1;
      out_byte_d  = conv.ch;
      out_last_d  = held_last_q;
      if (held_last_q) begin
        prev_sep_d   = 1'b1;
        in_sent_d    = 1'b0;
        held_valid_d = 1'b0;
        held_last_d  = 1'b0;
      end else begin
        prev_sep_d = conv.prev_sep;
        in_sent_d  = conv.in_sent;
      end
    end

    if (in_accept) begin
      held_d       = s_axis_tdata_i;
      held_valid_d = 1'b1;
      held_last_d  = s_axis_tlast_i;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= tcc_pkg::ModeReset;
      held_valid_q <= 1'b0;
      held_last_q  <= 1'b0;
      prev_sep_q   <= 1'b1;
      in_sent_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      held_valid_q <= held_valid_d;
      held_last_q  <= held_last_d;
      prev_sep_q   <= prev_sep_d;
      in_sent_q    <= in_sent_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    held_q     <= held_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

### src/tcc_checker.sv
// ----------------------------------------------------------------------------
// Text case converter checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
`include "text_case_converter_core_macros.svh"

module tcc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      cfg_we_i,
  input logic [tcc_pkg::ModeW-1:0] cfg_wdata_i,
  input logic                      s_axis_tvalid_i,
  input logic                      s_axis_tready_o,
  input logic                      s_axis_tlast_i,
  input logic                      m_axis_tvalid_o,
  input logic                      m_axis_tready_i,
  input logic [tcc_pkg::ByteW-1:0] m_axis_tdata_o,
  input logic                      m_axis_tlast_o
);

  logic [tcc_pkg::ModeW-1:0]  mode_q;
  logic [tcc_pkg::ByteW:0]    out_word;
  logic [tcc_pkg::ByteW:0]    out_word_q;
  logic                       out_stall;
  logic                       out_same;
  logic                       out_has_low;
  logic                       out_has_up;
  logic                       up_shown;
  logic                       low_shown;
  logic                       last_in;

  // Track the mode as written on the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tcc_pkg::ModeReset;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // Output contents of the previous cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_word_q <= '0;
    end else begin
      out_word_q <= out_word;
    end
  end

  assign out_word    = {m_axis_tlast_o, m_axis_tdata_o};
  assign out_stall   = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_same    = m_axis_tvalid_o && (out_word == out_word_q);
  assign out_has_low = tcc_pkg::is_low(m_axis_tdata_o);
  assign out_has_up  = tcc_pkg::is_up(m_axis_tdata_o);
  assign up_shown    = m_axis_tvalid_o && mode_q == tcc_pkg::MODE_UPPER;
  assign low_shown   = m_axis_tvalid_o && mode_q == tcc_pkg::MODE_LOWER;
  assign last_in     = s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i;

  // A stalled output item holds its contents.
  `TCC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_same, "stalled item changed")
  // The final byte of a text is flushed before new input is taken.
  `TCC_ASSERT_NEXT(a_last_blocks, clk_i, rst_ni, last_in, !s_axis_tready_o, "input during flush")
  // Upper mode never shows a lower-case letter.
  `TCC_ASSERT_SAME(a_upper_mode, clk_i, rst_ni, up_shown, !out_has_low, "lower case in upper mode")
  // Lower mode never shows an upper-case letter.
  `TCC_ASSERT_SAME(a_lower_mode, clk_i, rst_ni, low_shown, !out_has_up, "upper case in lower mode")

endmodule

bind text_case_converter_core tcc_checker u_tcc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cfg_we_i        (cfg_we_i),
  .cfg_wdata_i     (cfg_wdata_i),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

### dv/text_case_converter_core_tb.sv
// ----------------------------------------------------------------------------
// Text case converter core testbench
// Streams directed and random Latin-1 texts through the converter in every
// case mode, with random idling on both stream sides, and checks each output
// item against a cycle-free model of the conversion kept in the testbench.
// ----------------------------------------------------------------------------
module text_case_converter_core_tb;

  // Highest mode code; codes above sentence case pass bytes through.
  localparam logic [tcc_pkg::ModeW-1:0] ModeRawHi = 3'd7;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned PhaseItems  = 200;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned MaxShown    = 10;
  localparam int unsigned NumDirRows  = 25;

  // One converted byte as it leaves the block.
  typedef struct packed {
    logic [tcc_pkg::ByteW-1:0] ch;
    logic                      last;
  } out_item_t;

  // One row of the directed table; want is checked only when chk is set.
  typedef struct packed {
    logic [tcc_pkg::ModeW-1:0] mode;
    logic [tcc_pkg::ByteW-1:0] ch;
    logic                      last;
    logic                      chk;
    logic [tcc_pkg::ByteW-1:0] want;
  } dir_row_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [tcc_pkg::ModeW-1:0] cfg_wdata_i;
  logic                      s_axis_tvalid_i;
  logic                      s_axis_tready_o;
  logic [tcc_pkg::ByteW-1:0] s_axis_tdata_i;
  logic                      s_axis_tlast_i;
  logic                      m_axis_tvalid_o;
  logic                      m_axis_tready_i;
  logic [tcc_pkg::ByteW-1:0] m_axis_tdata_o;
  logic                      m_axis_tlast_o;

  // Model state of the converter.
  logic [tcc_pkg::ModeW-1:0] mode_q;
  logic [tcc_pkg::ByteW-1:0] held_ch;
  logic                      held_ok;
  logic                      after_sep;
  logic                      in_sentence;

  out_item_t   converted_q[$];
  int unsigned mismatch_count;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  dir_row_t    dir_rows [NumDirRows];

  text_case_converter_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // [7:0] text_byte
    .s_axis_tlast_i  (s_axis_tlast_i),   // end_of_text
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),   // [7:0] out_byte
    .m_axis_tlast_o  (m_axis_tlast_o)    // out_last
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard limit on the run time.
  initial begin
    #4000000;
    $display("text_case_converter_core_tb: FAIL");
    $finish;
  end

  // Character classes of the Latin-1 text.
  function automatic logic upper_letter(logic [tcc_pkg::ByteW-1:0] c);
    return (c >= tcc_pkg::ChUpA && c <= tcc_pkg::ChUpZ) ||
           (c >= tcc_pkg::Lat1UpLo && c <= tcc_pkg::Lat1UpHi);
  endfunction

  function automatic logic lower_letter(logic [tcc_pkg::ByteW-1:0] c);
    return (c >= tcc_pkg::ChLoA && c <= tcc_pkg::ChLoZ) || (c >= tcc_pkg::Lat1LoLo);
  endfunction

  function automatic logic [tcc_pkg::ByteW-1:0] raise_case(logic [tcc_pkg::ByteW-1:0] c);
    return lower_letter(c) ? c - tcc_pkg::CaseOffset : c;
  endfunction

  function automatic logic [tcc_pkg::ByteW-1:0] drop_case(logic [tcc_pkg::ByteW-1:0] c);
    return upper_letter(c) ? c + tcc_pkg::CaseOffset : c;
  endfunction

  // Anything but an ASCII letter, a digit or one of . _ - ' breaks a word.
  function automatic logic word_break(logic [tcc_pkg::ByteW-1:0] c);
    logic word_ch;
    word_ch = (c >= tcc_pkg::ChUpA && c <= tcc_pkg::ChUpZ) ||
              (c >= tcc_pkg::ChLoA && c <= tcc_pkg::ChLoZ) ||
              (c >= tcc_pkg::ChDig0 && c <= tcc_pkg::ChDig9) ||
              c == tcc_pkg::ChDot || c == tcc_pkg::ChUnder ||
              c == tcc_pkg::ChDash || c == tcc_pkg::ChApos;
    return !word_ch;
  endfunction

  // Convert a byte as it is released and update the word and sentence flags.
  function automatic logic [tcc_pkg::ByteW-1:0] release_char(
    logic [tcc_pkg::ByteW-1:0] c, logic next_brk);
    logic [tcc_pkg::ByteW-1:0] r;
    r = c;
    case (mode_q)
      tcc_pkg::MODE_UPPER:  r = raise_case(c);
      tcc_pkg::MODE_LOWER:  r = drop_case(c);
      tcc_pkg::MODE_TOGGLE: r = lower_letter(c) ? raise_case(c) : drop_case(c);
      tcc_pkg::MODE_WORD: begin
        if (upper_letter(c) && !after_sep) begin
          r = drop_case(c);
        end else if (lower_letter(c) && after_sep) begin
          r = raise_case(c);
        end
      end
      tcc_pkg::MODE_SENTENCE: begin
        if (in_sentence) begin
          // A lone i between separators is written upper case.
          if (raise_case(c) == tcc_pkg::ChUpI && after_sep && next_brk) begin
            r = tcc_pkg::ChUpI;
          end else begin
            r = drop_case(c);
          end
          if ((r == tcc_pkg::ChDot || r == tcc_pkg::ChBang || r == tcc_pkg::ChQuest) &&
              next_brk) begin
            in_sentence = 1'b0;
          end
        end else if (!word_break(c)) begin
          r           = raise_case(c);
          in_sentence = 1'b1;
        end
      end
      default: r = c;
    endcase
    after_sep = word_break(r);
    return r;
  endfunction

  // Expected output items for one accepted input item.
  task automatic predict_text_item(input logic [tcc_pkg::ByteW-1:0] c, input logic last);
    if (held_ok) begin
      converted_q.push_back('{ch: release_char(held_ch, word_break(c)), last: 1'b0});
    end
    if (last) begin
      converted_q.push_back('{ch: release_char(c, 1'b1), last: 1'b1});
      held_ch     = '0;
      held_ok     = 1'b0;
      after_sep   = 1'b1;
      in_sentence = 1'b0;
    end else begin
      held_ch = c;
      held_ok = 1'b1;
    end
  endtask

  // Offer one item, with an optional idle gap before it.
  task automatic send_byte(input logic [tcc_pkg::ByteW-1:0] c, input logic last);
    int unsigned gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(4, 1);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_text_item(c, last);
  endtask

  // Hold the input off until every expected item has come out.
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (converted_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [tcc_pkg::ModeW-1:0] m);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_q    = m;
  endtask

  task automatic set_idling(input int unsigned profile);
    case (profile % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 70; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 70; end
      default: begin send_idle_pct = 36; stall_pct = 36; end
    endcase
  endtask

  // Random text content: mostly words and punctuation, some raw bytes.
  function automatic logic [tcc_pkg::ByteW-1:0] pick_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) begin
      return tcc_pkg::ChLoA + tcc_pkg::ByteW'($urandom_range(25));
    end else if (r < 35) begin
      return tcc_pkg::ChUpA + tcc_pkg::ByteW'($urandom_range(25));
    end else if (r < 47) begin
      return 8'h20;
    end else if (r < 53) begin
      return $urandom_range(1) ? tcc_pkg::ChUpI : "i";
    end else if (r < 61) begin
      case ($urandom_range(2))
        0:       return tcc_pkg::ChDot;
        1:       return tcc_pkg::ChBang;
        default: return tcc_pkg::ChQuest;
      endcase
    end else if (r < 67) begin
      case ($urandom_range(3))
        0:       return tcc_pkg::ChUnder;
        1:       return tcc_pkg::ChDash;
        2:       return tcc_pkg::ChApos;
        default: return tcc_pkg::ChDig0 + tcc_pkg::ByteW'($urandom_range(9));
      endcase
    end else if (r < 71) begin
      return 8'h00;
    end else if (r < 82) begin
      return tcc_pkg::Lat1UpLo + tcc_pkg::ByteW'($urandom_range(63));
    end else begin
      return tcc_pkg::ByteW'($urandom_range(255));
    end
  endfunction

  // Output side: check each accepted item and stall at random.
  always @(posedge clk_i) begin
    out_item_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (converted_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxShown) begin
          $display("unexpected output item: byte %h last %b",
                   m_axis_tdata_o, m_axis_tlast_o);
        end
      end else begin
        want = converted_q.pop_front();
        if (m_axis_tdata_o != want.ch || m_axis_tlast_o != want.last) begin
          mismatch_count++;
          if (mismatch_count <= MaxShown) begin
            $display("mismatch: expected byte %h last %b, got byte %h last %b",
                     want.ch, want.last, m_axis_tdata_o, m_axis_tlast_o);
          end
        end
      end
    end
    m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Stimulus.
  initial begin
    logic [tcc_pkg::ModeW-1:0] phase_mode;
    int unsigned               sent;
    int unsigned               len;
    int unsigned               r;
    logic                      cut;
    logic                      done;

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    m_axis_tready_i = 1'b0;
    mismatch_count  = 0;
    mode_q          = tcc_pkg::ModeReset;
    held_ch         = '0;
    held_ok         = 1'b0;
    after_sep       = 1'b1;
    in_sentence     = 1'b0;
    set_idling(0);

    dir_rows = '{
      '{tcc_pkg::MODE_UPPER,    "a",   1'b1, 1'b1, "A"},
      '{tcc_pkg::MODE_UPPER,    8'hFF, 1'b1, 1'b1, 8'hDF},
      '{tcc_pkg::MODE_UPPER,    8'h00, 1'b1, 1'b1, 8'h00},
      '{tcc_pkg::MODE_UPPER,    8'hE0, 1'b1, 1'b1, 8'hC0},
      '{tcc_pkg::MODE_LOWER,    8'hC0, 1'b1, 1'b1, 8'hE0},
      '{tcc_pkg::MODE_LOWER,    8'hDF, 1'b1, 1'b1, 8'hFF},
      '{tcc_pkg::MODE_TOGGLE,   8'hF7, 1'b1, 1'b1, 8'hD7},
      '{tcc_pkg::MODE_TOGGLE,   8'hD7, 1'b1, 1'b1, 8'hF7},
      '{tcc_pkg::MODE_WORD,     "w",   1'b0, 1'b0, 8'h00},
      '{tcc_pkg::MODE_WORD,     "O",   1'b0, 1'b0, 8'h00},
      '{tcc_pkg::MODE_WORD,     " ",   1'b0, 1'b0, 8'h00},
      '{tcc_pkg::MODE_WORD,     "h",   1'b0, 1'b0, 8'h00},
      // The mode changes here while the h is still held.
      '{tcc_pkg::MODE_SENTENCE, "e",   1'b0, 1'b0, 8'h00},
      '{tcc_pkg::MODE_SENTENCE, " ",   1'b0, 1'b0, 8'h00},
      '{tcc_pkg::MODE_SENTENCE, "i",   1'b0, 1'b0, 8'h00},
      '{tcc_pkg::MODE_SENTENCE, " ",   1'b0, 1'b0, 8'h00},
      '{tcc_pkg::MODE_SENTENCE, "o",   1'b0, 1'b0, 8'h00},
      '{tcc_pkg::MODE_SENTENCE, "?",   1'b0, 1'b0, 8'h00},
      '{tcc_pkg::MODE_SENTENCE, " ",   1'b0, 1'b0, 8'h00},
      '{tcc_pkg::MODE_SENTENCE, "w",   1'b0, 1'b0, 8'h00},
      // A zero byte followed by a space must not end the sentence.
      '{tcc_pkg::MODE_SENTENCE, 8'h00, 1'b0, 1'b0, 8'h00},
      '{tcc_pkg::MODE_SENTENCE, " ",   1'b0, 1'b0, 8'h00},
      '{tcc_pkg::MODE_SENTENCE, "Z",   1'b0, 1'b0, 8'h00},
      '{tcc_pkg::MODE_SENTENCE, ".",   1'b1, 1'b0, 8'h00},
      '{ModeRawHi,              "a",   1'b1, 1'b1, "a"}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_mode(tcc_pkg::MODE_UPPER);

    // Directed table; the mode is switched only once every expected item has come out.
    for (int i = 0; i < NumDirRows; i++) begin
      if (dir_rows[i].mode != mode_q) begin
        wait_idle();
        write_mode(dir_rows[i].mode);
      end
      send_byte(dir_rows[i].ch, dir_rows[i].last);
      if (dir_rows[i].chk) begin
        converted_q[converted_q.size()-1].ch = dir_rows[i].want;
      end
    end

    // Random texts, one mode and one idling profile per phase.
    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_idle();
      case (ph)
        0:       phase_mode = tcc_pkg::MODE_SENTENCE;
        1:       phase_mode = tcc_pkg::MODE_UPPER;
        2:       phase_mode = tcc_pkg::MODE_WORD;
        3:       phase_mode = tcc_pkg::MODE_TOGGLE;
        4:       phase_mode = tcc_pkg::MODE_LOWER;
        5:       phase_mode = ModeRawHi;
        default: phase_mode = tcc_pkg::ModeW'($urandom_range(ModeRawHi));
      endcase
      write_mode(phase_mode);
      set_idling(ph);
      // Some phases stop in the middle of a text so the next mode takes over.
      cut  = (ph != NumPhases - 1) && ($urandom_range(1) == 1);
      sent = 0;
      done = 1'b0;
      while (!done) begin
        r = $urandom_range(99);
        if (r < 10) begin
          len = 1;
        end else if (r < 90) begin
          len = $urandom_range(24, 2);
        end else begin
          len = $urandom_range(60, 25);
        end
        for (int k = 0; k < len; k++) begin
          send_byte(pick_char(), k == len - 1);
          sent++;
          if (cut && sent >= PhaseItems) break;
        end
        if (sent >= PhaseItems) done = 1'b1;
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("text_case_converter_core_tb: PASS");
    end else begin
      $display("text_case_converter_core_tb: FAIL");
    end
    $finish;
  end

endmodule
